### rtl/abqa_pkg.sv
// shared types and constants for the arena block queue allocator
`default_nettype none
package abqa_pkg;
  localparam int MaxBlocks = 64;
  localparam int SlotW = $clog2(MaxBlocks);
  localparam int LinkW = SlotW + 1;
  localparam int QueueHdrBytes = 72;
  localparam int BlockHdrBytes = 40;
  localparam logic [LinkW-1:0] Nil = LinkW'(MaxBlocks);
  localparam int EntryW = 16 + 17 + 4 * LinkW;

  typedef enum logic [2:0] {
    REQ_ALLOC = 3'd0, REQ_REMOVE = 3'd1, REQ_STEP_ADDR = 3'd2,
    REQ_STEP_ARR = 3'd3, REQ_CLEAR = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BAD_HANDLE = 3'd1, ST_OVERFLOW = 3'd2, ST_TOO_MANY = 3'd3,
    ST_TOO_BIG = 3'd4, ST_NO_SPACE = 3'd5, ST_NO_BLOCK = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    CFG_ARENA_SIZE = 3'd0, CFG_COUNT_LIMIT_ON = 3'd1, CFG_COUNT_LIMIT = 3'd2,
    CFG_SIZE_LIMIT_ON = 3'd3, CFG_SIZE_LIMIT = 3'd4
  } cfg_e;

  typedef enum logic [1:0] {
    FLD_APREV = 2'd0, FLD_ANEXT = 2'd1, FLD_OPREV = 2'd2, FLD_ONEXT = 2'd3
  } link_fld_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_DECIDE, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_NX,
    S_SCAN_NXW, S_SCAN_EVAL, S_WR, S_OUT
  } state_e;

  typedef struct packed {
    logic [15:0]      offset;
    logic [16:0]      bytes;
    logic [LinkW-1:0] aprev;
    logic [LinkW-1:0] anext;
    logic [LinkW-1:0] oprev;
    logic [LinkW-1:0] onext;
  } entry_t;
endpackage
`default_nettype wire

### rtl/abqa_ram.sv
// generic single port ram with registered read
`default_nettype none
module abqa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

### rtl/arena_block_queue_allocator_top.sv
// arena block queue allocator: slot table in ram, sequencer for every request
`default_nettype none
// One request at a time; the next request is taken once the result has been
// accepted. A bad request or a clear goes straight to the result; a step reads
// the given block (unless it starts from a list head), then the block it links
// to. A remove reads the block, then does a read-modify-write of each
// neighbouring link. An allocation that fails its checks gives its result at
// once; otherwise blocks are scanned along the address list, each scanned
// block and its address successor read from the single-port slot table, before
// the new entry and link writes. Up to as many blocks as are live are scanned.
// Valid bits live in flip-flops; the table memory needs no clearing pass.
module arena_block_queue_allocator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [16:0] payload_bytes_i,
  input  wire logic [5:0]  handle_in_i,
  input  wire logic        from_start_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [5:0]       handle_o,
  output logic [15:0]      payload_offset_o,
  output logic [16:0]      block_bytes_o
);
  localparam int LW = abqa_pkg::LinkW;
  localparam int SW = abqa_pkg::SlotW;

  logic [16:0] arena_size_q, count_limit_q, size_limit_q;
  logic        cnt_on_q, size_on_q;
  logic [6:0]  cnt_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_size_q <= 17'd65536;
      cnt_on_q <= 1'b0;
      cnt_lim_q <= 7'd64;
      size_on_q <= 1'b0;
      size_limit_q <= 17'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        abqa_pkg::CFG_ARENA_SIZE: arena_size_q <= cfg_data_i;
        abqa_pkg::CFG_COUNT_LIMIT_ON: cnt_on_q <= cfg_data_i[0];
        abqa_pkg::CFG_COUNT_LIMIT: cnt_lim_q <= cfg_data_i[6:0];
        abqa_pkg::CFG_SIZE_LIMIT_ON: size_on_q <= cfg_data_i[0];
        abqa_pkg::CFG_SIZE_LIMIT: size_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign count_limit_q = {10'd0, cnt_lim_q};

  // ram
  logic                      we;
  logic [SW-1:0]             addr;
  abqa_pkg::entry_t          wdata, rdata;
  abqa_ram #(.Width(abqa_pkg::EntryW), .Depth(abqa_pkg::MaxBlocks)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  abqa_pkg::state_e state_q, state_d;
  logic [abqa_pkg::MaxBlocks-1:0] valid_q, valid_d;
  logic [LW-1:0] fa_q, fa_d, la_q, la_d, fo_q, fo_d, lo_q, lo_d;
  logic [LW-1:0] live_q, live_d;
  logic [17:0]   used_q, used_d;
  logic [2:0]    req_q, req_d;
  logic [16:0]   size_q, size_d;
  logic [SW-1:0] h_q, h_d;
  logic          start_q, start_d;
  logic [LW-1:0] n_q, n_d, t_q, t_d, k_q, k_d;
  abqa_pkg::entry_t te_q, te_d, ne_q, ne_d;
  // pending link writes: field select, slot, value
  logic [2:0]    wstep_q, wstep_d;
  logic [LW-1:0] wslot_q [4], wslot_d [4];
  logic [1:0]    wfld_q [4], wfld_d [4];
  logic [LW-1:0] wval_q [4], wval_d [4];
  logic [1:0]    rmw_q, rmw_d;
  abqa_pkg::entry_t newe_q, newe_d;
  logic          newwr_q, newwr_d;
  logic [2:0]    st_q, st_d;
  logic [5:0]    oh_q, oh_d;
  logic [15:0]   ooff_q, ooff_d;
  logic [16:0]   obytes_q, obytes_d;

  logic [16:0] arena;
  logic [17:0] need, endt, endt_need;
  logic [LW-1:0] free_n;
  logic          free_ok;

  always_comb begin
    arena = (arena_size_q > 17'd65536) ? 17'd65536 : arena_size_q;
    need = 18'(abqa_pkg::BlockHdrBytes) + {1'b0, size_q};
    endt = {2'b0, te_q.offset} + 18'(abqa_pkg::BlockHdrBytes) + {1'b0, te_q.bytes};
    endt_need = endt + need;
    free_n = abqa_pkg::Nil;
    free_ok = 1'b0;
    for (int i = abqa_pkg::MaxBlocks - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_n = LW'(i);
        free_ok = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= abqa_pkg::S_IDLE;
      valid_q <= '0;
      fa_q <= abqa_pkg::Nil; la_q <= abqa_pkg::Nil;
      fo_q <= abqa_pkg::Nil; lo_q <= abqa_pkg::Nil;
      live_q <= '0;
      used_q <= 18'(abqa_pkg::QueueHdrBytes);
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      fa_q <= fa_d; la_q <= la_d; fo_q <= fo_d; lo_q <= lo_d;
      live_q <= live_d;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; size_q <= size_d; h_q <= h_d; start_q <= start_d;
    n_q <= n_d; t_q <= t_d; k_q <= k_d; te_q <= te_d; ne_q <= ne_d;
    wstep_q <= wstep_d; wslot_q <= wslot_d; wfld_q <= wfld_d; wval_q <= wval_d;
    rmw_q <= rmw_d; newe_q <= newe_d; newwr_q <= newwr_d;
    st_q <= st_d; oh_q <= oh_d; ooff_q <= ooff_d; obytes_q <= obytes_d;
  end

  assign in_ready_o = (state_q == abqa_pkg::S_IDLE);
  assign out_valid_o = (state_q == abqa_pkg::S_OUT);
  assign status_o = st_q;
  assign handle_o = oh_q;
  assign payload_offset_o = ooff_q;
  assign block_bytes_o = obytes_q;

  always_comb begin
    abqa_pkg::entry_t m;
    logic [17:0] po;
    state_d = state_q; valid_d = valid_q;
    fa_d = fa_q; la_d = la_q; fo_d = fo_q; lo_d = lo_q;
    live_d = live_q; used_d = used_q;
    req_d = req_q; size_d = size_q; h_d = h_q; start_d = start_q;
    n_d = n_q; t_d = t_q; k_d = k_q; te_d = te_q; ne_d = ne_q;
    wstep_d = wstep_q; wslot_d = wslot_q; wfld_d = wfld_q; wval_d = wval_q;
    rmw_d = rmw_q; newe_d = newe_q; newwr_d = newwr_q;
    st_d = st_q; oh_d = oh_q; ooff_d = ooff_q; obytes_d = obytes_q;
    we = 1'b0; addr = h_q; wdata = rdata;
    m = rdata; po = '0;
    case (state_q)
      abqa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d = req_type_i; size_d = payload_bytes_i;
          h_d = handle_in_i; start_d = from_start_i;
          st_d = abqa_pkg::ST_OK; oh_d = '0; ooff_d = '0; obytes_d = '0;
          wstep_d = '0; newwr_d = 1'b0;
          state_d = abqa_pkg::S_DECIDE;
          if (req_type_i == abqa_pkg::REQ_REMOVE ||
              ((req_type_i == abqa_pkg::REQ_STEP_ADDR ||
                req_type_i == abqa_pkg::REQ_STEP_ARR) && !from_start_i)) begin
            if (!valid_q[handle_in_i]) begin
              st_d = abqa_pkg::ST_BAD_HANDLE;
              state_d = abqa_pkg::S_OUT;
            end else begin
              state_d = abqa_pkg::S_RD;
            end
          end else if (req_type_i == abqa_pkg::REQ_CLEAR) begin
            valid_d = '0;
            fa_d = abqa_pkg::Nil; la_d = abqa_pkg::Nil;
            fo_d = abqa_pkg::Nil; lo_d = abqa_pkg::Nil;
            live_d = '0; used_d = 18'(abqa_pkg::QueueHdrBytes);
            state_d = abqa_pkg::S_OUT;
          end else if (req_type_i > abqa_pkg::REQ_CLEAR) begin
            st_d = abqa_pkg::ST_BAD_HANDLE;
            state_d = abqa_pkg::S_OUT;
          end
        end
      end
      abqa_pkg::S_RD: begin
        addr = h_q;
        state_d = abqa_pkg::S_WAIT;
      end
      abqa_pkg::S_WAIT: begin
        addr = h_q;
        te_d = rdata;
        state_d = abqa_pkg::S_DECIDE;
      end
      abqa_pkg::S_DECIDE: begin
        t_d = abqa_pkg::Nil;
        case (req_q)
          abqa_pkg::REQ_STEP_ADDR, abqa_pkg::REQ_STEP_ARR: begin
            if (req_q == abqa_pkg::REQ_STEP_ADDR) begin
              t_d = start_q ? fa_q : te_q.anext;
            end else begin
              t_d = start_q ? fo_q : te_q.onext;
            end
            if (t_d == abqa_pkg::Nil) begin
              st_d = abqa_pkg::ST_NO_BLOCK;
              state_d = abqa_pkg::S_OUT;
            end else begin
              h_d = t_d[SW-1:0];
              state_d = abqa_pkg::S_SCAN_RD;
            end
          end
          abqa_pkg::REQ_REMOVE: begin
            oh_d = {{(6-SW){1'b0}}, h_q} ;
            po = {2'b0, te_q.offset} + 18'(abqa_pkg::BlockHdrBytes);
            ooff_d = po[15:0];
            obytes_d = te_q.bytes;
            live_d = live_q - 1'b1;
            used_d = used_q - 18'(abqa_pkg::BlockHdrBytes) - {1'b0, te_q.bytes};
            if (fa_q == {1'b0, h_q}) fa_d = te_q.anext;
            if (la_q == {1'b0, h_q}) la_d = te_q.aprev;
            if (fo_q == {1'b0, h_q}) fo_d = te_q.onext;
            if (lo_q == {1'b0, h_q}) lo_d = te_q.oprev;
            valid_d[h_q] = 1'b0;
            wslot_d[0] = te_q.aprev; wfld_d[0] = abqa_pkg::FLD_ANEXT; wval_d[0] = te_q.anext;
            wslot_d[1] = te_q.anext; wfld_d[1] = abqa_pkg::FLD_APREV; wval_d[1] = te_q.aprev;
            wslot_d[2] = te_q.oprev; wfld_d[2] = abqa_pkg::FLD_ONEXT; wval_d[2] = te_q.onext;
            wslot_d[3] = te_q.onext; wfld_d[3] = abqa_pkg::FLD_OPREV; wval_d[3] = te_q.oprev;
            wstep_d = '0; rmw_d = '0;
            state_d = abqa_pkg::S_WR;
          end
          default: begin
            // allocate checks
            if (used_q + {1'b0, size_q} > {1'b0, arena}) begin
              st_d = abqa_pkg::ST_OVERFLOW;
              state_d = abqa_pkg::S_OUT;
            end else if (cnt_on_q && {10'd0, live_q} + 17'd1 > count_limit_q) begin
              st_d = abqa_pkg::ST_TOO_MANY;
              state_d = abqa_pkg::S_OUT;
            end else if (size_on_q && size_q > size_limit_q) begin
              st_d = abqa_pkg::ST_TOO_BIG;
              state_d = abqa_pkg::S_OUT;
            end else if (!free_ok) begin
              st_d = abqa_pkg::ST_TOO_MANY;
              state_d = abqa_pkg::S_OUT;
            end else begin
              n_d = free_n;
              k_d = '0;
              if (fa_q == abqa_pkg::Nil) begin
                if (18'(abqa_pkg::QueueHdrBytes) + need > {1'b0, arena}) begin
                  st_d = abqa_pkg::ST_NO_SPACE;
                  state_d = abqa_pkg::S_OUT;
                end else begin
                  fa_d = free_n; la_d = free_n;
                  newe_d.offset = 16'(abqa_pkg::QueueHdrBytes);
                  newe_d.aprev = abqa_pkg::Nil; newe_d.anext = abqa_pkg::Nil;
                  state_d = abqa_pkg::S_WR;
                  newwr_d = 1'b1;
                end
              end else begin
                t_d = la_q;
                h_d = la_q[SW-1:0];
                state_d = abqa_pkg::S_SCAN_RD;
              end
              if (state_d == abqa_pkg::S_WR) begin
                newe_d.bytes = size_q;
                newe_d.oprev = lo_q; newe_d.onext = abqa_pkg::Nil;
                wslot_d[0] = abqa_pkg::Nil; wslot_d[1] = abqa_pkg::Nil;
                wslot_d[2] = lo_q; wfld_d[2] = abqa_pkg::FLD_ONEXT; wval_d[2] = free_n;
                wslot_d[3] = abqa_pkg::Nil;
                if (lo_q == abqa_pkg::Nil) fo_d = free_n;
                lo_d = free_n;
                wstep_d = '0; rmw_d = '0;
              end
            end
          end
        endcase
      end
      abqa_pkg::S_SCAN_RD: begin
        addr = h_q;
        state_d = abqa_pkg::S_SCAN_WAIT;
      end
      abqa_pkg::S_SCAN_WAIT: begin
        te_d = rdata;
        if (req_q != abqa_pkg::REQ_ALLOC) begin
          oh_d = {{(6-SW){1'b0}}, h_q};
          po = {2'b0, rdata.offset} + 18'(abqa_pkg::BlockHdrBytes);
          ooff_d = po[15:0];
          obytes_d = rdata.bytes;
          state_d = abqa_pkg::S_OUT;
        end else if (rdata.anext != abqa_pkg::Nil) begin
          addr = rdata.anext[SW-1:0];
          state_d = abqa_pkg::S_SCAN_NX;
        end else begin
          state_d = abqa_pkg::S_SCAN_EVAL;
        end
      end
      abqa_pkg::S_SCAN_NX: begin
        addr = te_q.anext[SW-1:0];
        state_d = abqa_pkg::S_SCAN_NXW;
      end
      abqa_pkg::S_SCAN_NXW: begin
        ne_d = rdata;
        state_d = abqa_pkg::S_SCAN_EVAL;
      end
      abqa_pkg::S_SCAN_EVAL: begin
        newe_d.bytes = size_q;
        newe_d.oprev = lo_q; newe_d.onext = abqa_pkg::Nil;
        wslot_d[0] = abqa_pkg::Nil; wslot_d[1] = abqa_pkg::Nil;
        wslot_d[2] = lo_q; wfld_d[2] = abqa_pkg::FLD_ONEXT; wval_d[2] = n_q;
        wslot_d[3] = abqa_pkg::Nil;
        wstep_d = '0; rmw_d = '0;
        state_d = abqa_pkg::S_WR;
        newwr_d = 1'b1;
        if (te_q.anext == abqa_pkg::Nil && endt_need <= {1'b0, arena}) begin
          newe_d.offset = endt[15:0];
          newe_d.aprev = t_q; newe_d.anext = abqa_pkg::Nil;
          wslot_d[0] = t_q; wfld_d[0] = abqa_pkg::FLD_ANEXT; wval_d[0] = n_q;
          la_d = n_q;
        end else if (te_q.aprev == abqa_pkg::Nil &&
                     18'(abqa_pkg::QueueHdrBytes) + need <= {2'b0, te_q.offset}) begin
          newe_d.offset = 16'(abqa_pkg::QueueHdrBytes);
          newe_d.aprev = abqa_pkg::Nil; newe_d.anext = t_q;
          wslot_d[0] = t_q; wfld_d[0] = abqa_pkg::FLD_APREV; wval_d[0] = n_q;
          fa_d = n_q;
        end else if (te_q.anext != abqa_pkg::Nil &&
                     endt_need <= {2'b0, ne_q.offset}) begin
          newe_d.offset = endt[15:0];
          newe_d.aprev = t_q; newe_d.anext = te_q.anext;
          wslot_d[0] = t_q; wfld_d[0] = abqa_pkg::FLD_ANEXT; wval_d[0] = n_q;
          wslot_d[1] = te_q.anext; wfld_d[1] = abqa_pkg::FLD_APREV; wval_d[1] = n_q;
        end else begin
          newwr_d = 1'b0;
          k_d = k_q + 1'b1;
          t_d = (te_q.anext != abqa_pkg::Nil) ? te_q.anext : fa_q;
          h_d = t_d[SW-1:0];
          if (k_q + 1'b1 >= live_q) begin
            st_d = abqa_pkg::ST_NO_SPACE;
            state_d = abqa_pkg::S_OUT;
          end else begin
            state_d = abqa_pkg::S_SCAN_RD;
          end
        end
        if (state_d == abqa_pkg::S_WR) begin
          if (lo_q == abqa_pkg::Nil) fo_d = n_q;
          lo_d = n_q;
        end
      end
      abqa_pkg::S_WR: begin
        if (newwr_q) begin
          // write new entry first
          addr = n_q[SW-1:0];
          we = 1'b1;
          wdata = newe_q;
          valid_d[n_q[SW-1:0]] = 1'b1;
          live_d = live_q + 1'b1;
          used_d = used_q + 18'(abqa_pkg::BlockHdrBytes) + {1'b0, newe_q.bytes};
          oh_d = n_q[5:0];
          po = {2'b0, newe_q.offset} + 18'(abqa_pkg::BlockHdrBytes);
          ooff_d = po[15:0];
          obytes_d = newe_q.bytes;
          newwr_d = 1'b0;
        end else if (wstep_q[2]) begin
          state_d = abqa_pkg::S_OUT;
        end else if (wslot_q[wstep_q[1:0]] == abqa_pkg::Nil) begin
          wstep_d = wstep_q + 1'b1;
        end else begin
          addr = wslot_q[wstep_q[1:0]][SW-1:0];
          case (rmw_q)
            2'd0: rmw_d = 2'd1;
            2'd1: rmw_d = 2'd2;
            default: begin
              m = rdata;
              case (wfld_q[wstep_q[1:0]])
                abqa_pkg::FLD_APREV: m.aprev = wval_q[wstep_q[1:0]];
                abqa_pkg::FLD_ANEXT: m.anext = wval_q[wstep_q[1:0]];
                abqa_pkg::FLD_OPREV: m.oprev = wval_q[wstep_q[1:0]];
                default: m.onext = wval_q[wstep_q[1:0]];
              endcase
              we = 1'b1;
              wdata = m;
              rmw_d = 2'd0;
              wstep_d = wstep_q + 1'b1;
            end
          endcase
        end
      end
      abqa_pkg::S_OUT: begin
        if (out_ready_i) state_d = abqa_pkg::S_IDLE;
      end
      default: state_d = abqa_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### tb/tb.sv
// testbench for the arena block queue allocator: predictor, stimulus and result checks
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;
  localparam int HoldCycles = 400;
  localparam int MaxBlocks = abqa_pkg::MaxBlocks;
  localparam int QueueHdrBytes = abqa_pkg::QueueHdrBytes;
  localparam int BlockHdrBytes = abqa_pkg::BlockHdrBytes;

  typedef struct {
    abqa_pkg::status_e st;
    logic [5:0]  h;
    logic [15:0] off;
    logic [16:0] bb;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  req_type_i = '0;
  logic [16:0] payload_bytes_i = '0;
  logic [5:0]  handle_in_i = '0;
  logic        from_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [5:0]  handle_o;
  logic [15:0] payload_offset_o;
  logic [16:0] block_bytes_o;

  arena_block_queue_allocator_top i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // allocator state as predicted
  int m_arena, m_cnt_on, m_cnt_lim, m_size_on, m_size_lim;
  bit m_valid[MaxBlocks];
  int m_off[MaxBlocks], m_bytes[MaxBlocks];
  int m_aprev[MaxBlocks], m_anext[MaxBlocks], m_oprev[MaxBlocks], m_onext[MaxBlocks];
  int m_first_a, m_last_a, m_first_o, m_last_o;
  int m_live, m_used;

  result_t pending_results[$];
  int      mismatches = 0;
  bit      idle_on = 1'b1;
  bit      hold_req = 1'b0;
  int      quiet_cycles = 0;

  function automatic void clear_arena();
    for (int i = 0; i < MaxBlocks; i++) m_valid[i] = 1'b0;
    m_first_a = MaxBlocks; m_last_a = MaxBlocks;
    m_first_o = MaxBlocks; m_last_o = MaxBlocks;
    m_live = 0;
    m_used = QueueHdrBytes;
  endfunction

  function automatic result_t make_result(abqa_pkg::status_e st, int slot);
    result_t r;
    r.st = st;
    r.h = '0; r.off = '0; r.bb = '0;
    if (st == abqa_pkg::ST_OK && slot < MaxBlocks) begin
      r.h = slot[5:0];
      r.off = 16'(m_off[slot] + BlockHdrBytes);
      r.bb = 17'(m_bytes[slot]);
    end
    return r;
  endfunction

  function automatic int block_end(int s);
    return m_off[s] + BlockHdrBytes + m_bytes[s];
  endfunction

  function automatic void fill_slot(int n, int off, int size);
    m_valid[n] = 1'b1;
    m_off[n] = off;
    m_bytes[n] = size;
    m_oprev[n] = m_last_o;
    m_onext[n] = MaxBlocks;
    if (m_last_o < MaxBlocks) m_onext[m_last_o] = n;
    else m_first_o = n;
    m_last_o = n;
    m_live++;
    m_used += BlockHdrBytes + size;
  endfunction

  function automatic abqa_pkg::status_e place_block(int size, output int slot);
    int arena, need, n, t, nx;
    arena = m_arena > 65536 ? 65536 : m_arena;
    need = BlockHdrBytes + size;
    slot = MaxBlocks;
    if (m_used + size > arena) return abqa_pkg::ST_OVERFLOW;
    if (m_cnt_on != 0 && m_live + 1 > m_cnt_lim) return abqa_pkg::ST_TOO_MANY;
    if (m_size_on != 0 && size > m_size_lim) return abqa_pkg::ST_TOO_BIG;
    n = 0;
    while (n < MaxBlocks && m_valid[n]) n++;
    if (n >= MaxBlocks) return abqa_pkg::ST_TOO_MANY;
    if (m_first_a >= MaxBlocks) begin
      if (QueueHdrBytes + need > arena) return abqa_pkg::ST_NO_SPACE;
      fill_slot(n, QueueHdrBytes, size);
      m_aprev[n] = MaxBlocks; m_anext[n] = MaxBlocks;
      m_first_a = n; m_last_a = n;
      slot = n;
      return abqa_pkg::ST_OK;
    end
    t = m_last_a;
    for (int k = 0; k < m_live && t < MaxBlocks; k++) begin
      nx = m_anext[t];
      if (nx >= MaxBlocks && block_end(t) + need <= arena) begin
        fill_slot(n, block_end(t), size);
        m_aprev[n] = t; m_anext[n] = MaxBlocks; m_anext[t] = n;
        m_last_a = n;
        slot = n;
        return abqa_pkg::ST_OK;
      end
      if (m_aprev[t] >= MaxBlocks && QueueHdrBytes + need <= m_off[t]) begin
        fill_slot(n, QueueHdrBytes, size);
        m_aprev[n] = MaxBlocks; m_anext[n] = t; m_aprev[t] = n;
        m_first_a = n;
        slot = n;
        return abqa_pkg::ST_OK;
      end
      if (nx < MaxBlocks && block_end(t) + need <= m_off[nx]) begin
        fill_slot(n, block_end(t), size);
        m_aprev[n] = t; m_anext[n] = nx; m_anext[t] = n; m_aprev[nx] = n;
        slot = n;
        return abqa_pkg::ST_OK;
      end
      t = nx < MaxBlocks ? nx : m_first_a;
    end
    return abqa_pkg::ST_NO_SPACE;
  endfunction

  function automatic void unlink_block(int h);
    int ap, an, op, on;
    ap = m_aprev[h]; an = m_anext[h]; op = m_oprev[h]; on = m_onext[h];
    m_live--;
    m_used -= BlockHdrBytes + m_bytes[h];
    if (m_first_a == h) m_first_a = an;
    if (m_last_a == h) m_last_a = ap;
    if (m_first_o == h) m_first_o = on;
    if (m_last_o == h) m_last_o = op;
    if (ap < MaxBlocks) m_anext[ap] = an;
    if (an < MaxBlocks) m_aprev[an] = ap;
    if (op < MaxBlocks) m_onext[op] = on;
    if (on < MaxBlocks) m_oprev[on] = op;
    m_valid[h] = 1'b0;
  endfunction

  function automatic result_t predict_request(logic [2:0] req, int size, int h, bit fs);
    int slot, nxt;
    abqa_pkg::status_e st;
    result_t r;
    case (req)
      abqa_pkg::REQ_ALLOC: begin
        st = place_block(size, slot);
        r = make_result(st, slot);
      end
      abqa_pkg::REQ_REMOVE: begin
        if (!m_valid[h]) r = make_result(abqa_pkg::ST_BAD_HANDLE, MaxBlocks);
        else begin
          r = make_result(abqa_pkg::ST_OK, h);
          unlink_block(h);
        end
      end
      abqa_pkg::REQ_STEP_ADDR, abqa_pkg::REQ_STEP_ARR: begin
        if (!fs && !m_valid[h]) r = make_result(abqa_pkg::ST_BAD_HANDLE, MaxBlocks);
        else begin
          if (req == abqa_pkg::REQ_STEP_ADDR) nxt = fs ? m_first_a : m_anext[h];
          else nxt = fs ? m_first_o : m_onext[h];
          r = nxt < MaxBlocks ? make_result(abqa_pkg::ST_OK, nxt)
                              : make_result(abqa_pkg::ST_NO_BLOCK, MaxBlocks);
        end
      end
      abqa_pkg::REQ_CLEAR: begin
        clear_arena();
        r = make_result(abqa_pkg::ST_OK, MaxBlocks);
      end
      default: r = make_result(abqa_pkg::ST_BAD_HANDLE, MaxBlocks);
    endcase
    return r;
  endfunction

  function automatic int pick_live();
    int live[$];
    for (int i = 0; i < MaxBlocks; i++) if (m_valid[i]) live.push_back(i);
    if (live.size() == 0) return $urandom_range(0, MaxBlocks - 1);
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  task automatic send_request(logic [2:0] req, int size, int h, bit fs);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    payload_bytes_i <= 17'(size);
    handle_in_i <= 6'(h);
    from_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_request(req, size, h, fs));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(abqa_pkg::cfg_e idx, int val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 17'(val);
    @(posedge clk_i);
  endtask

  task automatic set_config(int arena, int cnt_on, int cnt_lim, int size_on, int size_lim);
    write_reg(abqa_pkg::CFG_ARENA_SIZE, arena);
    write_reg(abqa_pkg::CFG_COUNT_LIMIT_ON, cnt_on);
    write_reg(abqa_pkg::CFG_COUNT_LIMIT, cnt_lim);
    write_reg(abqa_pkg::CFG_SIZE_LIMIT_ON, size_on);
    write_reg(abqa_pkg::CFG_SIZE_LIMIT, size_lim);
    cfg_we_i <= 1'b0;
    m_arena = arena & 'h1FFFF; m_cnt_on = cnt_on & 1; m_cnt_lim = cnt_lim & 'h7F;
    m_size_on = size_on & 1; m_size_lim = size_lim & 'h1FFFF;
    @(posedge clk_i);
  endtask

  task automatic random_request();
    int r, size;
    r = $urandom_range(0, 99);
    size = $urandom_range(0, 19) == 0 ? $urandom_range(0, 65536) : $urandom_range(0, 400);
    if (r < 45)
      send_request(abqa_pkg::REQ_ALLOC, size, $urandom_range(0, 63), $urandom_range(0, 1));
    else if (r < 68)
      send_request(abqa_pkg::REQ_REMOVE, size, pick_live(), $urandom_range(0, 1));
    else if (r < 72)
      send_request(abqa_pkg::REQ_REMOVE, size, $urandom_range(0, 63), $urandom_range(0, 1));
    else if (r < 88)
      send_request($urandom_range(0, 1) ? abqa_pkg::REQ_STEP_ADDR : abqa_pkg::REQ_STEP_ARR,
                   size, pick_live(), $urandom_range(0, 3) == 0);
    else if (r < 94)
      send_request($urandom_range(0, 1) ? abqa_pkg::REQ_STEP_ADDR : abqa_pkg::REQ_STEP_ARR,
                   size, $urandom_range(0, 63), $urandom_range(0, 1));
    else if (r < 95)
      send_request(abqa_pkg::REQ_CLEAR, size, $urandom_range(0, 63), $urandom_range(0, 1));
    else send_request(3'($urandom_range(5, 7)), size, $urandom_range(0, 63), $urandom_range(0, 1));
  endtask

  task automatic test_directed();
    send_request(abqa_pkg::REQ_STEP_ADDR, 0, 0, 1'b1);
    send_request(abqa_pkg::REQ_STEP_ARR, 0, 0, 1'b1);
    send_request(abqa_pkg::REQ_REMOVE, 0, 63, 1'b0);
    send_request(abqa_pkg::REQ_STEP_ADDR, 0, 5, 1'b0);
    send_request(3'd5, 65536, 63, 1'b1);
    send_request(3'd6, 0, 0, 1'b0);
    send_request(3'd7, 131071, 63, 1'b1);
    send_request(abqa_pkg::REQ_ALLOC, 65536, 0, 1'b0);
    send_request(abqa_pkg::REQ_ALLOC, 0, 0, 1'b0);
    send_request(abqa_pkg::REQ_ALLOC, 65535 - 72 - 80, 0, 1'b0);
    send_request(abqa_pkg::REQ_ALLOC, 100, 0, 1'b0);
    send_request(abqa_pkg::REQ_REMOVE, 0, 1, 1'b0);
    send_request(abqa_pkg::REQ_ALLOC, 0, 0, 1'b0);
    send_request(abqa_pkg::REQ_STEP_ADDR, 0, 0, 1'b1);
    send_request(abqa_pkg::REQ_STEP_ADDR, 0, 0, 1'b0);
    send_request(abqa_pkg::REQ_STEP_ARR, 0, 1, 1'b0);
    send_request(abqa_pkg::REQ_STEP_ARR, 0, 2, 1'b0);
    send_request(abqa_pkg::REQ_CLEAR, 0, 0, 1'b0);
    send_request(abqa_pkg::REQ_STEP_ARR, 0, 0, 1'b0);
    drain();
  endtask

  task automatic test_limits();
    set_config(112, 1, 0, 1, 0);
    send_request(abqa_pkg::REQ_ALLOC, 0, 0, 1'b0);
    drain();
    set_config(112, 0, 127, 1, 0);
    send_request(abqa_pkg::REQ_ALLOC, 1, 0, 1'b0);
    send_request(abqa_pkg::REQ_ALLOC, 0, 0, 1'b0);
    send_request(abqa_pkg::REQ_ALLOC, 0, 0, 1'b0);
    send_request(abqa_pkg::REQ_CLEAR, 0, 0, 1'b0);
    drain();
    set_config(131071, 1, 3, 1, 100);
    for (int i = 0; i < 5; i++) send_request(abqa_pkg::REQ_ALLOC, 99 + i, 0, 1'b0);
    send_request(abqa_pkg::REQ_CLEAR, 0, 0, 1'b0);
    drain();
  endtask

  task automatic test_full_table();
    set_config(65536, 0, 64, 0, 131071);
    for (int i = 0; i < MaxBlocks + 1; i++) send_request(abqa_pkg::REQ_ALLOC, 0, 0, 1'b0);
    for (int i = 10; i < 20; i += 3) send_request(abqa_pkg::REQ_REMOVE, 0, i, 1'b0);
    for (int i = 0; i < 4; i++) send_request(abqa_pkg::REQ_ALLOC, 0, 0, 1'b0);
    send_request(abqa_pkg::REQ_CLEAR, 0, 0, 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) random_request();
    drain();
  endtask

  task automatic test_random_phase(int arena, int cnt_on, int cnt_lim, int size_on,
                                   int size_lim, int items);
    set_config(arena, cnt_on, cnt_lim, size_on, size_lim);
    for (int i = 0; i < items; i++) random_request();
    drain();
  endtask

  // receiver side ready, with stall bursts and one long hold-off
  initial begin
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d handle %0d", status_o,
                                       handle_o);
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.st || handle_o !== e.h || payload_offset_o !== e.off ||
            block_bytes_o !== e.bb) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st %0d h %0d off %0d bytes %0d, got %0d %0d %0d %0d",
                     e.st, e.h, e.off, e.bb, status_o, handle_o, payload_offset_o,
                     block_bytes_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    m_arena = 65536; m_cnt_on = 0; m_cnt_lim = 64; m_size_on = 0; m_size_lim = 65536;
    clear_arena();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limits();
    test_full_table();
    test_backpressure();
    test_random_phase(65536, 0, 64, 0, 65536, 400);
    test_random_phase(1500, 1, 10, 1, 200, 400);
    test_random_phase(112, 0, 127, 0, 131071, 150);
    test_random_phase(3000, 1, 64, 1, 65536, 400);
    test_random_phase(131071, 1, 40, 0, 300, 250);
    idle_on = 1'b0;
    test_random_phase(2000, 0, 64, 0, 65536, 150);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
rtl/abqa_pkg.sv
rtl/abqa_ram.sv
rtl/arena_block_queue_allocator_top.sv
tb/tb.sv
